@@ sv/dsched_pkg.sv @@
// shared types, constants and helpers for the disk request scheduler
package dsched_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int TRACK_BITS = 17;
    localparam int FIELD_BITS = 17;
    localparam int STAMP_BITS = 32;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SERVE = 1'b1;

    typedef enum logic [1:0] {
        POL_FCFS  = 2'd0,
        POL_SSTF  = 2'd1,
        POL_LOOK  = 2'd2,
        POL_CLOOK = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        STAT_SERVED = 2'd0,
        STAT_STORED = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SCAN_OLDEST = 2'd0,
        SCAN_LEFT   = 2'd1,
        SCAN_RIGHT  = 2'd2,
        SCAN_MAX    = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PASS_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        scan_mode_t              mode;
        logic [TRACK_BITS-1:0]   head;
        logic [TRACK_BITS-1:0]   cand_track;
        logic [STAMP_BITS-1:0]   cand_age;
        logic                    best_found;
        logic [TRACK_BITS-1:0]   best_track;
        logic [STAMP_BITS-1:0]   best_age;
    } cmp_req_t;

    // lowest free entry
    function automatic logic [IDX_BITS-1:0] first_free(input logic [DEPTH-1:0] v);
        logic [IDX_BITS-1:0] idx;
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = IDX_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ sv/dsched_mem.sv @@
// track and arrival stamp storage, one write port and one registered read port
module dsched_mem (
    input  logic                               clk,
    input  logic                               we,
    input  logic [dsched_pkg::IDX_BITS-1:0]    waddr,
    input  logic [dsched_pkg::TRACK_BITS-1:0]  wtrack,
    input  logic [dsched_pkg::STAMP_BITS-1:0]  wstamp,
    input  logic [dsched_pkg::IDX_BITS-1:0]    raddr,
    output logic [dsched_pkg::TRACK_BITS-1:0]  rtrack,
    output logic [dsched_pkg::STAMP_BITS-1:0]  rstamp
);
    import dsched_pkg::*;

    logic [TRACK_BITS-1:0] track_mem [DEPTH];
    logic [STAMP_BITS-1:0] stamp_mem [DEPTH];
    logic [TRACK_BITS-1:0] rtrack_reg;
    logic [STAMP_BITS-1:0] rstamp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            track_mem[waddr] <= wtrack;
            stamp_mem[waddr] <= wstamp;
        end
    end

    always_ff @(posedge clk)
    begin
        rtrack_reg <= track_mem[raddr];
        rstamp_reg <= stamp_mem[raddr];
    end

    assign rtrack = rtrack_reg;
    assign rstamp = rstamp_reg;

endmodule

@@ sv/dsched_cmp.sv @@
// shared compare unit: decides whether a scanned entry replaces the current best
module dsched_cmp (
    input  dsched_pkg::cmp_req_t req,
    output logic                 take
);
    import dsched_pkg::*;

    logic qual;
    logic older;

    always_comb
    begin
        qual  = !((req.mode == SCAN_LEFT)  && (req.cand_track > req.head)) &&
                !((req.mode == SCAN_RIGHT) && (req.cand_track < req.head));
        older = req.cand_age > req.best_age;
        take  = 1'b0;
        if (qual)
        begin
            if (!req.best_found)
            begin
                take = 1'b1;
            end
            else
            begin
                case (req.mode)
                    SCAN_OLDEST: take = older;
                    SCAN_RIGHT:  take = (req.cand_track < req.best_track) ||
                                        ((req.cand_track == req.best_track) && older);
                    default:     take = (req.cand_track > req.best_track) ||
                                        ((req.cand_track == req.best_track) && older);
                endcase
            end
        end
    end

endmodule

@@ sv/disk_request_scheduler.sv @@
// disk request scheduler top level: pending store, scan sequencer and result register
//
// Holds up to 64 pending track requests. An add request is answered in the
// cycle after it is taken. A serve request runs one or two scan passes over
// the store with a single shared compare unit, one entry per cycle through the
// store's registered read port; FCFS uses one pass, LOOK and C-LOOK one or
// two, and SSTF two (a left and a right pass). Serving an empty store or
// adding to a full one answers without a scan. The input is stalled while a
// serve is in progress or a result waits to be taken.
// Writing start_head also moves the head; write it only while idle.
module disk_request_scheduler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start_head_we,
    input  logic [dsched_pkg::FIELD_BITS-1:0]  start_head,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [dsched_pkg::FIELD_BITS-1:0]  track,
    input  logic [1:0]                         policy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dsched_pkg::FIELD_BITS-1:0]  served_track,
    output logic [1:0]                         status
);
    import dsched_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [IDX_BITS-1:0]   pipe_idx_reg, pipe_idx_next;
    logic                  pipe_ev_reg, pipe_ev_next;
    scan_mode_t            mode_reg, mode_next;
    logic                  pass2_reg, pass2_next;
    policy_t               policy_reg, policy_next;
    logic                  best_found_reg, best_found_next;
    logic [IDX_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [TRACK_BITS-1:0] best_track_reg, best_track_next;
    logic [STAMP_BITS-1:0] best_age_reg, best_age_next;
    logic                  save_found_reg, save_found_next;
    logic [IDX_BITS-1:0]   save_idx_reg, save_idx_next;
    logic [TRACK_BITS-1:0] save_track_reg, save_track_next;
    logic                  pick_found_reg, pick_found_next;
    logic [IDX_BITS-1:0]   pick_idx_reg, pick_idx_next;
    logic [TRACK_BITS-1:0] pick_track_reg, pick_track_next;
    logic [TRACK_BITS-1:0] head_reg, head_next;
    logic                  sweep_left_reg, sweep_left_next;
    logic [STAMP_BITS-1:0] next_stamp_reg, next_stamp_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] out_track_reg, out_track_next;
    status_t               out_status_reg, out_status_next;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [TRACK_BITS-1:0] mem_wtrack;
    logic [TRACK_BITS-1:0] rd_track;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [STAMP_BITS-1:0] rd_age;
    cmp_req_t              cmp_req;
    logic                  cmp_take;
    logic                  accept;
    logic                  out_free;
    logic [IDX_BITS-1:0]   free_idx;
    logic [TRACK_BITS-1:0] dist_l;
    logic [TRACK_BITS-1:0] dist_r;

    dsched_mem u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wtrack (mem_wtrack),
        .wstamp (next_stamp_reg),
        .raddr  (cnt_reg[IDX_BITS-1:0]),
        .rtrack (rd_track),
        .rstamp (rd_stamp)
    );

    dsched_cmp u_cmp (
        .req  (cmp_req),
        .take (cmp_take)
    );

    assign rd_age   = next_stamp_reg - rd_stamp;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign free_idx = first_free(valid_reg);
    assign dist_l   = head_reg - save_track_reg;
    assign dist_r   = best_track_reg - head_reg;

    always_comb
    begin
        cmp_req.mode       = mode_reg;
        cmp_req.head       = head_reg;
        cmp_req.cand_track = rd_track;
        cmp_req.cand_age   = rd_age;
        cmp_req.best_found = best_found_reg;
        cmp_req.best_track = best_track_reg;
        cmp_req.best_age   = best_age_reg;
    end

    assign out_valid    = out_valid_reg;
    assign served_track = out_track_reg;
    assign status       = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            mode_reg       <= SCAN_OLDEST;
            pass2_reg      <= 1'b0;
            policy_reg     <= POL_FCFS;
            best_found_reg <= 1'b0;
            save_found_reg <= 1'b0;
            pick_found_reg <= 1'b0;
            head_reg       <= '0;
            sweep_left_reg <= 1'b1;
            next_stamp_reg <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_SERVED;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            mode_reg       <= mode_next;
            pass2_reg      <= pass2_next;
            policy_reg     <= policy_next;
            best_found_reg <= best_found_next;
            save_found_reg <= save_found_next;
            pick_found_reg <= pick_found_next;
            head_reg       <= head_next;
            sweep_left_reg <= sweep_left_next;
            next_stamp_reg <= next_stamp_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        pipe_ev_reg    <= pipe_ev_next;
        best_idx_reg   <= best_idx_next;
        best_track_reg <= best_track_next;
        best_age_reg   <= best_age_next;
        save_idx_reg   <= save_idx_next;
        save_track_reg <= save_track_next;
        pick_idx_reg   <= pick_idx_next;
        pick_track_reg <= pick_track_next;
        out_track_reg  <= out_track_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        pipe_ev_next    = pipe_ev_reg;
        mode_next       = mode_reg;
        pass2_next      = pass2_reg;
        policy_next     = policy_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_track_next = best_track_reg;
        best_age_next   = best_age_reg;
        save_found_next = save_found_reg;
        save_idx_next   = save_idx_reg;
        save_track_next = save_track_reg;
        pick_found_next = pick_found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_track_next = pick_track_reg;
        head_next       = head_reg;
        sweep_left_next = sweep_left_reg;
        next_stamp_next = next_stamp_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        out_track_next  = out_track_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wtrack      = TRACK_BITS'(track);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (start_head_we)
        begin
            head_next = TRACK_BITS'(start_head);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_ADD)
                    begin
                        out_valid_next = 1'b1;
                        out_track_next = '0;
                        if (&valid_reg)
                        begin
                            out_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            next_stamp_next      = next_stamp_reg + 1'b1;
                            out_status_next      = STAT_STORED;
                        end
                    end
                    else if (valid_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_track_next  = '0;
                        out_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        policy_next     = policy_t'(policy);
                        pass2_next      = 1'b0;
                        best_found_next = 1'b0;
                        cnt_next        = '0;
                        state_next      = ST_SCAN;
                        case (policy_t'(policy))
                            POL_FCFS: mode_next = SCAN_OLDEST;
                            POL_LOOK: mode_next = sweep_left_reg ? SCAN_LEFT : SCAN_RIGHT;
                            default:  mode_next = SCAN_LEFT;
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                if (pipe_vld_reg && pipe_ev_reg && cmp_take)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pipe_idx_reg;
                    best_track_next = rd_track;
                    best_age_next   = rd_age;
                end
                if (cnt_reg != CNT_BITS'(DEPTH))
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[IDX_BITS-1:0];
                    pipe_ev_next  = valid_reg[cnt_reg[IDX_BITS-1:0]];
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_PASS_END;
                end
            end

            ST_PASS_END:
            begin
                pick_found_next = best_found_reg;
                pick_idx_next   = best_idx_reg;
                pick_track_next = best_track_reg;
                state_next      = ST_FINISH;
                case (policy_reg)
                    POL_SSTF:
                    begin
                        if (!pass2_reg)
                        begin
                            save_found_next = best_found_reg;
                            save_idx_next   = best_idx_reg;
                            save_track_next = best_track_reg;
                            mode_next       = SCAN_RIGHT;
                            state_next      = ST_SCAN;
                        end
                        else if (save_found_reg && (!best_found_reg || dist_l <= dist_r))
                        begin
                            pick_found_next = 1'b1;
                            pick_idx_next   = save_idx_reg;
                            pick_track_next = save_track_reg;
                        end
                    end
                    POL_LOOK:
                    begin
                        if (!best_found_reg && !pass2_reg)
                        begin
                            sweep_left_next = !sweep_left_reg;
                            mode_next       = sweep_left_reg ? SCAN_RIGHT : SCAN_LEFT;
                            state_next      = ST_SCAN;
                        end
                    end
                    POL_CLOOK:
                    begin
                        if (!best_found_reg && !pass2_reg)
                        begin
                            mode_next  = SCAN_MAX;
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (state_next == ST_SCAN)
                begin
                    pass2_next      = 1'b1;
                    best_found_next = 1'b0;
                    cnt_next        = '0;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (pick_found_reg)
                    begin
                        valid_next[pick_idx_reg] = 1'b0;
                        head_next                = pick_track_reg;
                        out_track_next           = FIELD_BITS'(pick_track_reg);
                        out_status_next          = STAT_SERVED;
                    end
                    else
                    begin
                        out_track_next  = '0;
                        out_status_next = STAT_EMPTY;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
